@@ sv/e8ce_pkg.sv @@
// Shared types, constants and code tables of the EAN-8 check and encode core.
package e8ce_pkg;

  localparam int DIGIT_W = 4;
  localparam int SEG_BITS_W = 7;
  localparam int SEG_LEN_W = 3;
  localparam int STATUS_W = 2;
  localparam int SEG_IDX_W = 4;
  localparam int SUM_W = 8;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NONDIGIT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_MISMATCH = 2'd2;

  // Segment positions in bar order.
  localparam logic [SEG_IDX_W-1:0] SEG_START = 4'd0;
  localparam logic [SEG_IDX_W-1:0] SEG_LEFT_0 = 4'd1;
  localparam logic [SEG_IDX_W-1:0] SEG_LEFT_1 = 4'd2;
  localparam logic [SEG_IDX_W-1:0] SEG_LEFT_2 = 4'd3;
  localparam logic [SEG_IDX_W-1:0] SEG_LEFT_3 = 4'd4;
  localparam logic [SEG_IDX_W-1:0] SEG_CENTRE = 4'd5;
  localparam logic [SEG_IDX_W-1:0] SEG_RIGHT_0 = 4'd6;
  localparam logic [SEG_IDX_W-1:0] SEG_RIGHT_1 = 4'd7;
  localparam logic [SEG_IDX_W-1:0] SEG_RIGHT_2 = 4'd8;
  localparam logic [SEG_IDX_W-1:0] SEG_RIGHT_3 = 4'd9;
  localparam logic [SEG_IDX_W-1:0] SEG_END = 4'd10;

  localparam logic [DIGIT_W-1:0] MAX_DIGIT = 4'd9;
  localparam int CHECK_BASE = 10;

  // Guard patterns, left-aligned, first module in the top bit.
  localparam logic [SEG_BITS_W-1:0] GUARD_BITS = 7'h50;
  localparam logic [SEG_BITS_W-1:0] CENTRE_BITS = 7'h28;
  localparam logic [SEG_LEN_W-1:0] LEN_GUARD = 3'd3;
  localparam logic [SEG_LEN_W-1:0] LEN_CENTRE = 3'd5;
  localparam logic [SEG_LEN_W-1:0] LEN_CODE = 3'd7;

  typedef struct packed {
    logic [DIGIT_W-1:0] digit_0;
    logic [DIGIT_W-1:0] digit_1;
    logic [DIGIT_W-1:0] digit_2;
    logic [DIGIT_W-1:0] digit_3;
    logic [DIGIT_W-1:0] digit_4;
    logic [DIGIT_W-1:0] digit_5;
    logic [DIGIT_W-1:0] digit_6;
    logic [DIGIT_W-1:0] check_digit;
  } e8ce_in_t;

  typedef struct packed {
    logic [SEG_BITS_W-1:0] segment_bits;
    logic [SEG_LEN_W-1:0] segment_length;
    logic [STATUS_W-1:0] status;
    logic last;
  } e8ce_out_t;

  // Left-hand (set A) code of a digit.
  function automatic logic [SEG_BITS_W-1:0] left_code(input logic [DIGIT_W-1:0] d);
    logic [SEG_BITS_W-1:0] c;
    unique case (d)
      4'd0: c = 7'h0D;
      4'd1: c = 7'h19;
      4'd2: c = 7'h13;
      4'd3: c = 7'h3D;
      4'd4: c = 7'h23;
      4'd5: c = 7'h31;
      4'd6: c = 7'h2F;
      4'd7: c = 7'h3B;
      4'd8: c = 7'h37;
      4'd9: c = 7'h0B;
      default: c = '0;
    endcase
    return c;
  endfunction

  // Right-hand (set C) code of a digit.
  function automatic logic [SEG_BITS_W-1:0] right_code(input logic [DIGIT_W-1:0] d);
    logic [SEG_BITS_W-1:0] c;
    unique case (d)
      4'd0: c = 7'h72;
      4'd1: c = 7'h66;
      4'd2: c = 7'h6C;
      4'd3: c = 7'h42;
      4'd4: c = 7'h5C;
      4'd5: c = 7'h4E;
      4'd6: c = 7'h50;
      4'd7: c = 7'h44;
      4'd8: c = 7'h48;
      4'd9: c = 7'h74;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

@@ sv/e8ce_check.sv @@
// Digit range test and check digit verification for one EAN-8 number.
module e8ce_check import e8ce_pkg::*; (
  input  e8ce_in_t            item,
  output logic [STATUS_W-1:0] status
);

  logic [DIGIT_W-1:0] dig [8];
  logic               nondigit;
  logic [SUM_W-1:0]   odd_sum;
  logic [SUM_W-1:0]   even_sum;
  logic [SUM_W-1:0]   total;
  logic               multiple;

  assign dig[0] = item.digit_0;
  assign dig[1] = item.digit_1;
  assign dig[2] = item.digit_2;
  assign dig[3] = item.digit_3;
  assign dig[4] = item.digit_4;
  assign dig[5] = item.digit_5;
  assign dig[6] = item.digit_6;
  assign dig[7] = item.check_digit;

  always_comb begin
    nondigit = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (dig[i] > MAX_DIGIT) begin
        nondigit = 1'b1;
      end
    end
  end

  // The check digit is right exactly when weighted sum plus check digit is a
  // multiple of ten, since the check digit itself is below ten.
  assign odd_sum = SUM_W'(dig[0]) + SUM_W'(dig[2]) + SUM_W'(dig[4]) + SUM_W'(dig[6]);
  assign even_sum = SUM_W'(dig[1]) + SUM_W'(dig[3]) + SUM_W'(dig[5]) + SUM_W'(dig[7]);
  assign total = SUM_W'((odd_sum << 1) + odd_sum + even_sum);

  always_comb begin
    multiple = 1'b0;
    for (int k = 0; k < 15; k++) begin
      if (total == SUM_W'(k * CHECK_BASE)) begin
        multiple = 1'b1;
      end
    end
  end

  always_comb begin
    priority if (nondigit) begin
      status = ST_NONDIGIT;
    end else if (!multiple) begin
      status = ST_MISMATCH;
    end else begin
      status = ST_OK;
    end
  end

endmodule

@@ sv/e8ce_seg.sv @@
// Module pattern and length of one segment of a validated EAN-8 number.
module e8ce_seg import e8ce_pkg::*; (
  input  logic [SEG_IDX_W-1:0]  idx,
  input  e8ce_in_t              dig,
  output logic [SEG_BITS_W-1:0] bits,
  output logic [SEG_LEN_W-1:0]  len
);

  always_comb begin
    unique case (idx)
      SEG_START: begin
        bits = GUARD_BITS;
        len = LEN_GUARD;
      end
      SEG_LEFT_0: begin
        bits = left_code(dig.digit_0);
        len = LEN_CODE;
      end
      SEG_LEFT_1: begin
        bits = left_code(dig.digit_1);
        len = LEN_CODE;
      end
      SEG_LEFT_2: begin
        bits = left_code(dig.digit_2);
        len = LEN_CODE;
      end
      SEG_LEFT_3: begin
        bits = left_code(dig.digit_3);
        len = LEN_CODE;
      end
      SEG_CENTRE: begin
        bits = CENTRE_BITS;
        len = LEN_CENTRE;
      end
      SEG_RIGHT_0: begin
        bits = right_code(dig.digit_4);
        len = LEN_CODE;
      end
      SEG_RIGHT_1: begin
        bits = right_code(dig.digit_5);
        len = LEN_CODE;
      end
      SEG_RIGHT_2: begin
        bits = right_code(dig.digit_6);
        len = LEN_CODE;
      end
      SEG_RIGHT_3: begin
        bits = right_code(dig.check_digit);
        len = LEN_CODE;
      end
      SEG_END: begin
        bits = GUARD_BITS;
        len = LEN_GUARD;
      end
      default: begin
        bits = '0;
        len = '0;
      end
    endcase
  end

endmodule

@@ sv/e8ce_emit.sv @@
// Segment sequencer and output register: walks one item through its results.
module e8ce_emit import e8ce_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                src_vld,
  input  e8ce_in_t            src_item,
  input  logic [STATUS_W-1:0] src_status,
  output logic                src_take,
  output logic                out_valid,
  input  logic                out_ready,
  output e8ce_out_t           out_data
);

  logic                  busy_r, busy_nxt;
  logic [SEG_IDX_W-1:0]  idx_r, idx_nxt;
  e8ce_in_t              dig_r, dig_nxt;
  logic                  out_vld_r, out_vld_nxt;
  e8ce_out_t             out_data_r, out_data_nxt;
  logic                  adv;
  logic [SEG_BITS_W-1:0] seg_bits;
  logic [SEG_LEN_W-1:0]  seg_len;

  e8ce_seg u_seg (
    .idx  (idx_r),
    .dig  (dig_r),
    .bits (seg_bits),
    .len  (seg_len)
  );

  // The output register moves on when it is empty or its transfer completes.
  assign adv = !out_vld_r || out_ready;

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt = idx_r;
    dig_nxt = dig_r;
    out_vld_nxt = out_vld_r;
    out_data_nxt = out_data_r;
    src_take = 1'b0;
    if (adv) begin
      if (busy_r) begin
        out_vld_nxt = 1'b1;
        out_data_nxt.segment_bits = seg_bits;
        out_data_nxt.segment_length = seg_len;
        out_data_nxt.status = ST_OK;
        out_data_nxt.last = (idx_r == SEG_END);
        idx_nxt = SEG_IDX_W'(idx_r + 1'b1);
        if (idx_r == SEG_END) begin
          busy_nxt = 1'b0;
        end
      end else if (src_vld) begin
        src_take = 1'b1;
        out_vld_nxt = 1'b1;
        dig_nxt = src_item;
        if (src_status != ST_OK) begin
          out_data_nxt.segment_bits = '0;
          out_data_nxt.segment_length = '0;
          out_data_nxt.status = src_status;
          out_data_nxt.last = 1'b1;
        end else begin
          // The start guard needs no digit, so it goes out in the load cycle.
          out_data_nxt.segment_bits = GUARD_BITS;
          out_data_nxt.segment_length = LEN_GUARD;
          out_data_nxt.status = ST_OK;
          out_data_nxt.last = 1'b0;
          busy_nxt = 1'b1;
          idx_nxt = SEG_LEFT_0;
        end
      end else begin
        out_vld_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r <= SEG_START;
      out_vld_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      idx_r <= idx_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dig_r <= dig_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_data = out_data_r;

`ifndef ASSERT_OFF
  a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && (out_data_r.status != ST_OK) |-> out_data_r.last)
    else $error("error result not flagged last");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (idx_r != SEG_START) && (idx_r <= SEG_END))
    else $error("segment index out of range while busy");

  a_more_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_data_r.last |-> busy_r)
    else $error("non-final segment without further segments pending");

  a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
    src_take |-> !busy_r)
    else $error("new item taken while segments remain");

  a_empty_is_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && (out_data_r.segment_length == '0) |-> (out_data_r.status != ST_OK))
    else $error("empty segment with ok status");
`endif

endmodule

@@ sv/ean8_check_and_encode_core.sv @@
// EAN-8 check and encode core: input register, check logic and segment sequencer.
//
// Usage: an EAN-8 number enters on in_data (seven data digits and the check
// digit) with the in_valid/in_ready handshake. Results leave on out_data with
// out_valid/out_ready, one result per transfer.
// A number with a digit code above nine, or with a wrong check digit, gives a
// single result with zero length, the error status and last set. A valid
// number gives eleven segments in bar order: start guard, four left codes,
// centre guard, four right codes and end guard; last marks the end guard.
// The first result passes through the input register, then the output
// register, as soon as the output register is free.
// The segment sequencer emits one segment per cycle unless the receiver stalls;
// it holds a valid number for eleven segments and a rejected number for one.
// The input register takes the next number while the current one is still
// being emitted. When the receiver stalls, the output register holds its
// result and the input register fills, after which in_ready drops.
// Reset clears all valid flags and the sequencer; no results are pending.
module ean8_check_and_encode_core import e8ce_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  e8ce_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output e8ce_out_t out_data
);

  logic                in_full_r, in_full_nxt;
  e8ce_in_t            item_r, item_nxt;
  logic [STATUS_W-1:0] item_status;
  logic                take;

  e8ce_check u_check (
    .item   (item_r),
    .status (item_status)
  );

  e8ce_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .src_vld    (in_full_r),
    .src_item   (item_r),
    .src_status (item_status),
    .src_take   (take),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  assign in_ready = !in_full_r || take;

  always_comb begin
    in_full_nxt = in_full_r;
    item_nxt = item_r;
    if (take) begin
      in_full_nxt = 1'b0;
    end
    if (in_valid && in_ready) begin
      in_full_nxt = 1'b1;
      item_nxt = in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r <= 1'b0;
    end else begin
      in_full_r <= in_full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench of the EAN-8 check and encode core.
`timescale 1ns / 100ps

module tb_top;
  import e8ce_pkg::*;

  localparam int RANDOM_ITEMS = 390;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 24;

  // Standard EAN left-hand (set A) and right-hand (set C) digit codes.
  localparam logic [SEG_BITS_W-1:0] SET_A_CODE [10] = '{
    7'h0D, 7'h19, 7'h13, 7'h3D, 7'h23, 7'h31, 7'h2F, 7'h3B, 7'h37, 7'h0B
  };
  localparam logic [SEG_BITS_W-1:0] SET_C_CODE [10] = '{
    7'h72, 7'h66, 7'h6C, 7'h42, 7'h5C, 7'h4E, 7'h50, 7'h44, 7'h48, 7'h74
  };

  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_FIX_CHECK,
    ROW_TYPED
  } row_kind_t;

  typedef struct packed {
    logic [31:0] digits;
    row_kind_t kind;
    logic [STATUS_W-1:0] status;
  } dir_row_t;

  typedef struct packed {
    logic typed;
    logic [STATUS_W-1:0] status;
  } item_note_t;

  // Digits are written left to right as they appear on the label; the last
  // nibble is the check digit.
  localparam int NUM_DIR_ROWS = 21;
  localparam dir_row_t DIR_ROWS [NUM_DIR_ROWS] = '{
    '{32'h00000000, ROW_PREDICT, ST_OK},
    '{32'h99999995, ROW_PREDICT, ST_OK},
    '{32'h12345670, ROW_PREDICT, ST_OK},
    '{32'h99999999, ROW_TYPED, ST_MISMATCH},
    '{32'h12345671, ROW_TYPED, ST_MISMATCH},
    '{32'h00000001, ROW_TYPED, ST_MISMATCH},
    '{32'hFFFFFFFF, ROW_TYPED, ST_NONDIGIT},
    '{32'hA0000000, ROW_TYPED, ST_NONDIGIT},
    '{32'h000000A0, ROW_TYPED, ST_NONDIGIT},
    '{32'h0000000F, ROW_TYPED, ST_NONDIGIT},
    '{32'h0B000003, ROW_TYPED, ST_NONDIGIT},
    '{32'h01234560, ROW_FIX_CHECK, ST_OK},
    '{32'h12345670, ROW_FIX_CHECK, ST_OK},
    '{32'h23456780, ROW_FIX_CHECK, ST_OK},
    '{32'h34567890, ROW_FIX_CHECK, ST_OK},
    '{32'h45678900, ROW_FIX_CHECK, ST_OK},
    '{32'h56789010, ROW_FIX_CHECK, ST_OK},
    '{32'h67890120, ROW_FIX_CHECK, ST_OK},
    '{32'h78901230, ROW_FIX_CHECK, ST_OK},
    '{32'h89012340, ROW_FIX_CHECK, ST_OK},
    '{32'h90123450, ROW_FIX_CHECK, ST_OK}
  };

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  e8ce_in_t in_data;
  logic out_valid;
  logic out_ready;
  e8ce_out_t out_data;

  e8ce_out_t segment_expect_q[$];
  item_note_t item_note_q[$];
  item_note_t note_now;
  int mismatch_count = 0;
  int cycle_count = 0;
  bit send_quiet = 0;
  bit take_quiet = 0;

  ean8_check_and_encode_core uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [DIGIT_W-1:0] digit_at(input e8ce_in_t x, input int pos);
    logic [31:0] flat;
    flat = x;
    return flat[(7 - pos) * DIGIT_W +: DIGIT_W];
  endfunction

  // Weighted sum 3,1,3,... over the seven data digits, closed to a multiple of ten.
  function automatic logic [DIGIT_W-1:0] ean8_check_of(input e8ce_in_t x);
    int weighted_sum;
    weighted_sum = 0;
    for (int i = 0; i < 7; i++) begin
      weighted_sum += ((i % 2 == 0) ? 3 : 1) * int'(digit_at(x, i));
    end
    return DIGIT_W'((CHECK_BASE - weighted_sum % CHECK_BASE) % CHECK_BASE);
  endfunction

  function automatic void push_segment(input logic [SEG_BITS_W-1:0] bits,
                                       input logic [SEG_LEN_W-1:0] len,
                                       input logic [STATUS_W-1:0] st, input logic fin);
    e8ce_out_t seg;
    seg.segment_bits = bits;
    seg.segment_length = len;
    seg.status = st;
    seg.last = fin;
    segment_expect_q.push_back(seg);
  endfunction

  function automatic void predict_segments(input e8ce_in_t x);
    bit has_nondigit;
    has_nondigit = 0;
    for (int i = 0; i < 8; i++) begin
      if (digit_at(x, i) > MAX_DIGIT) has_nondigit = 1;
    end
    if (has_nondigit) begin
      push_segment('0, '0, ST_NONDIGIT, 1'b1);
    end else if (ean8_check_of(x) != x.check_digit) begin
      push_segment('0, '0, ST_MISMATCH, 1'b1);
    end else begin
      push_segment(GUARD_BITS, LEN_GUARD, ST_OK, 1'b0);
      for (int i = 0; i < 4; i++) begin
        push_segment(SET_A_CODE[digit_at(x, i)], LEN_CODE, ST_OK, 1'b0);
      end
      push_segment(CENTRE_BITS, LEN_CENTRE, ST_OK, 1'b0);
      for (int i = 4; i < 8; i++) begin
        push_segment(SET_C_CODE[digit_at(x, i)], LEN_CODE, ST_OK, 1'b0);
      end
      push_segment(GUARD_BITS, LEN_GUARD, ST_OK, 1'b1);
    end
  endfunction

  task automatic check_segment(input e8ce_out_t got);
    e8ce_out_t want;
    if (segment_expect_q.size() == 0) begin
      $error("unexpected result transfer: %p", got);
      mismatch_count++;
    end else begin
      want = segment_expect_q.pop_front();
      if (got.segment_bits !== want.segment_bits) begin
        $error("segment_bits expected %h got %h", want.segment_bits, got.segment_bits);
        mismatch_count++;
      end
      if (got.segment_length !== want.segment_length) begin
        $error("segment_length expected %0d got %0d", want.segment_length,
               got.segment_length);
        mismatch_count++;
      end
      if (got.status !== want.status) begin
        $error("status expected %0d got %0d", want.status, got.status);
        mismatch_count++;
      end
      if (got.last !== want.last) begin
        $error("last expected %0d got %0d", want.last, got.last);
        mismatch_count++;
      end
    end
  endtask

  // Both transfers are observed here, so expectations are queued and consumed
  // in one place at each rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid === 1'b1 && out_ready) check_segment(out_data);
      if (in_valid && in_ready === 1'b1) begin
        note_now = item_note_q.pop_front();
        if (note_now.typed) begin
          push_segment('0, '0, note_now.status, 1'b1);
        end else begin
          predict_segments(in_data);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_number(input e8ce_in_t x, input logic typed,
                             input logic [STATUS_W-1:0] st);
    int gap;
    item_note_t note;
    gap = send_quiet ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    note.typed = typed;
    note.status = st;
    item_note_q.push_back(note);
    in_data = x;
    in_valid = 1'b1;
    do @(posedge clk); while (in_ready !== 1'b1);
    @(negedge clk);
  endtask

  // Mostly well-formed numbers; the rest have a wrong check digit, a stray
  // non-digit, or are raw random bits.
  function automatic e8ce_in_t random_number();
    e8ce_in_t x;
    logic [31:0] flat;
    int pick;
    int pos;
    pick = $urandom_range(0, 99);
    for (int i = 0; i < 8; i++) begin
      flat[(7 - i) * DIGIT_W +: DIGIT_W] = DIGIT_W'($urandom_range(0, 9));
    end
    x = flat;
    x.check_digit = ean8_check_of(x);
    if (pick >= 70 && pick < 85) begin
      x.check_digit = DIGIT_W'((int'(x.check_digit) + $urandom_range(1, 9)) % CHECK_BASE);
    end else if (pick >= 85 && pick < 95) begin
      pos = $urandom_range(0, 7);
      flat = x;
      flat[(7 - pos) * DIGIT_W +: DIGIT_W] = DIGIT_W'($urandom_range(10, 15));
      x = flat;
    end else if (pick >= 95) begin
      x = $urandom;
    end
    return x;
  endfunction

  initial begin
    e8ce_in_t item;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    for (int r = 0; r < NUM_DIR_ROWS; r++) begin
      item = DIR_ROWS[r].digits;
      if (DIR_ROWS[r].kind == ROW_FIX_CHECK) item.check_digit = ean8_check_of(item);
      send_number(item, DIR_ROWS[r].kind == ROW_TYPED, DIR_ROWS[r].status);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 32 == 0) send_quiet = ($urandom_range(0, 3) == 0);
      send_number(random_number(), 1'b0, ST_OK);
    end
    in_valid = 1'b0;

    while (segment_expect_q.size() != 0 || item_note_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Receiver side: a random stall before each result, with quiet stretches.
  initial begin
    int stall;
    int taken;
    taken = 0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (taken % 32 == 0) take_quiet = ($urandom_range(0, 3) == 0);
      stall = take_quiet ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      taken++;
      @(negedge clk);
    end
  end

endmodule
